// ===== src/http_request_line_checker_assert.svh =====
// Assertion macros for the HTTP request line checker.
`ifndef HTTP_REQUEST_LINE_CHECKER_ASSERT_SVH
`define HTTP_REQUEST_LINE_CHECKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HRLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HRLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hrlc_pkg.sv =====
// Shared types, codes, character tables and limits of the HTTP request line checker.
`timescale 1ns / 1ps
`default_nettype none

package hrlc_pkg;

    localparam int METHOD_LIMIT_DEF  = 8;
    localparam int PATH_LIMIT_DEF    = 256;
    localparam int VERSION_LIMIT_DEF = 16;

    localparam int OUT_TDATA_W = 16;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    // "GET", padded to a power-of-two depth
    localparam logic [7:0] GET_TEXT [4] = '{8'h47, 8'h45, 8'h54, 8'h00};

    // "HTTP/1.0" and "HTTP/1.1"
    localparam logic [7:0] VER_TEN [8] =
        '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h30};
    localparam logic [7:0] VER_ELEVEN [8] =
        '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31};

    typedef enum logic [2:0] {
        V_SIMPLE = 3'd0,
        V_FULL   = 3'd1,
        V_UNTERM = 3'd2,
        V_MLONG  = 3'd3,
        V_NOTGET = 3'd4,
        V_PLONG  = 3'd5,
        V_VLONG  = 3'd6,
        V_BADVER = 3'd7
    } verdict_t;

    typedef enum logic [3:0] {
        PH_METHOD  = 4'b0001,
        PH_PATH    = 4'b0010,
        PH_VERSION = 4'b0100,
        PH_DRAIN   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       valid;
        verdict_t   verdict;
        logic [7:0] path_length;
    } result_t;

    function automatic verdict_t judge_version(input logic len_ok, input logic ten,
                                               input logic eleven);
        return (len_ok && (ten || eleven)) ? V_FULL : V_BADVER;
    endfunction

endpackage

`default_nettype wire

// ===== src/hrlc_core.sv =====
// Per-byte parse state and verdict logic of the HTTP request line checker.
`timescale 1ns / 1ps
`default_nettype none

module hrlc_core #(
    parameter int METHOD_LIMIT  = hrlc_pkg::METHOD_LIMIT_DEF,
    parameter int PATH_LIMIT    = hrlc_pkg::PATH_LIMIT_DEF,
    parameter int VERSION_LIMIT = hrlc_pkg::VERSION_LIMIT_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      data_byte,
    input  wire logic            end_of_request,
    output hrlc_pkg::result_t    result
);

    localparam int FIELD_LIMIT = (METHOD_LIMIT > VERSION_LIMIT) ? METHOD_LIMIT : VERSION_LIMIT;
    localparam int FIELD_W     = $clog2(FIELD_LIMIT);
    localparam int PATH_W      = $clog2(PATH_LIMIT);
    localparam int PX_W        = (PATH_W > 8) ? PATH_W : 8;

    hrlc_pkg::phase_t     phase_reg, phase_next;
    logic [FIELD_W-1:0]   field_count_reg, field_count_next;
    logic                 method_matches_reg, method_matches_next;
    logic                 ver_ten_reg, ver_ten_next;
    logic                 ver_eleven_reg, ver_eleven_next;
    logic [PATH_W-1:0]    path_count_reg, path_count_next;

    logic                 emit;
    hrlc_pkg::verdict_t   emit_verdict;
    logic [PATH_W-1:0]    emit_pc;
    logic [PX_W-1:0]      pc_ext;

    always_comb
    begin
        phase_next          = phase_reg;
        field_count_next    = field_count_reg;
        method_matches_next = method_matches_reg;
        ver_ten_next        = ver_ten_reg;
        ver_eleven_next     = ver_eleven_reg;
        path_count_next     = path_count_reg;
        emit                = 1'b0;
        emit_verdict        = hrlc_pkg::V_SIMPLE;
        emit_pc             = path_count_reg;

        if (step)
        begin
            unique case (phase_reg)
                hrlc_pkg::PH_METHOD:
                begin
                    if (data_byte == hrlc_pkg::CHAR_SP)
                    begin
                        if (!(method_matches_reg && field_count_reg == FIELD_W'(3)))
                        begin
                            emit         = 1'b1;
                            emit_verdict = hrlc_pkg::V_NOTGET;
                        end
                        else
                        begin
                            phase_next       = hrlc_pkg::PH_PATH;
                            field_count_next = '0;
                            path_count_next  = '0;
                            emit_pc          = '0;
                            if (end_of_request)
                            begin
                                emit         = 1'b1;
                                emit_verdict = hrlc_pkg::V_SIMPLE;
                            end
                        end
                    end
                    else if (data_byte == hrlc_pkg::CHAR_NUL)
                    begin
                        emit         = 1'b1;
                        emit_verdict = hrlc_pkg::V_UNTERM;
                    end
                    else if (field_count_reg >= FIELD_W'(METHOD_LIMIT - 1))
                    begin
                        emit         = 1'b1;
                        emit_verdict = hrlc_pkg::V_MLONG;
                    end
                    else
                    begin
                        if (field_count_reg >= FIELD_W'(3) ||
                            hrlc_pkg::GET_TEXT[field_count_reg[1:0]] != data_byte)
                        begin
                            method_matches_next = 1'b0;
                        end
                        field_count_next = FIELD_W'(field_count_reg + 1'b1);
                        if (end_of_request)
                        begin
                            emit         = 1'b1;
                            emit_verdict = hrlc_pkg::V_UNTERM;
                        end
                    end
                end
                hrlc_pkg::PH_PATH:
                begin
                    if (data_byte == hrlc_pkg::CHAR_SP || data_byte == hrlc_pkg::CHAR_NUL)
                    begin
                        phase_next       = hrlc_pkg::PH_VERSION;
                        field_count_next = '0;
                        ver_ten_next     = 1'b1;
                        ver_eleven_next  = 1'b1;
                        if (end_of_request)
                        begin
                            emit         = 1'b1;
                            emit_verdict = hrlc_pkg::judge_version(1'b0, 1'b1, 1'b1);
                        end
                    end
                    else if (path_count_reg >= PATH_W'(PATH_LIMIT - 1))
                    begin
                        emit         = 1'b1;
                        emit_verdict = hrlc_pkg::V_PLONG;
                    end
                    else
                    begin
                        path_count_next = PATH_W'(path_count_reg + 1'b1);
                        emit_pc         = path_count_next;
                        if (end_of_request)
                        begin
                            emit         = 1'b1;
                            emit_verdict = hrlc_pkg::V_SIMPLE;
                        end
                    end
                end
                hrlc_pkg::PH_VERSION:
                begin
                    if (data_byte == hrlc_pkg::CHAR_SP || data_byte == hrlc_pkg::CHAR_CR ||
                        data_byte == hrlc_pkg::CHAR_NUL)
                    begin
                        emit         = 1'b1;
                        emit_verdict = hrlc_pkg::judge_version(
                            field_count_reg == FIELD_W'(8), ver_ten_reg, ver_eleven_reg);
                    end
                    else if (field_count_reg >= FIELD_W'(VERSION_LIMIT - 1))
                    begin
                        emit         = 1'b1;
                        emit_verdict = hrlc_pkg::V_VLONG;
                    end
                    else
                    begin
                        if (field_count_reg >= FIELD_W'(8))
                        begin
                            ver_ten_next    = 1'b0;
                            ver_eleven_next = 1'b0;
                        end
                        else
                        begin
                            if (hrlc_pkg::VER_TEN[field_count_reg[2:0]] != data_byte)
                                ver_ten_next = 1'b0;
                            if (hrlc_pkg::VER_ELEVEN[field_count_reg[2:0]] != data_byte)
                                ver_eleven_next = 1'b0;
                        end
                        field_count_next = FIELD_W'(field_count_reg + 1'b1);
                        if (end_of_request)
                        begin
                            emit         = 1'b1;
                            emit_verdict = hrlc_pkg::judge_version(
                                field_count_next == FIELD_W'(8), ver_ten_next, ver_eleven_next);
                        end
                    end
                end
                hrlc_pkg::PH_DRAIN:
                begin
                    if (end_of_request)
                        phase_next = hrlc_pkg::PH_METHOD;
                end
                default:
                begin
                    phase_next = hrlc_pkg::PH_METHOD;
                end
            endcase

            if (emit && !end_of_request)
                phase_next = hrlc_pkg::PH_DRAIN;

            // rearm after the end mark
            if (end_of_request && (emit || phase_reg == hrlc_pkg::PH_DRAIN))
            begin
                phase_next          = hrlc_pkg::PH_METHOD;
                field_count_next    = '0;
                method_matches_next = 1'b1;
                ver_ten_next        = 1'b1;
                ver_eleven_next     = 1'b1;
                path_count_next     = '0;
            end
        end
    end

    assign pc_ext = PX_W'(emit_pc);

    always_comb
    begin
        result.valid       = emit;
        result.verdict     = emit_verdict;
        result.path_length = (pc_ext > PX_W'(255)) ? 8'hFF : pc_ext[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= hrlc_pkg::PH_METHOD;
            field_count_reg    <= '0;
            method_matches_reg <= 1'b1;
            ver_ten_reg        <= 1'b1;
            ver_eleven_reg     <= 1'b1;
            path_count_reg     <= '0;
        end
        else
        begin
            phase_reg          <= phase_next;
            field_count_reg    <= field_count_next;
            method_matches_reg <= method_matches_next;
            ver_ten_reg        <= ver_ten_next;
            ver_eleven_reg     <= ver_eleven_next;
            path_count_reg     <= path_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/http_request_line_checker.sv =====
// Top level of the HTTP request line checker: input register, parse core, result register.
//
//  channel  | dir | fields
//  ---------+-----+-------------------------------------------------------
//  s_axis   | in  | tdata[7:0] data_byte, tlast end_of_request
//  m_axis   | out | tdata[2:0] verdict, tdata[10:3] path_length, rest zero
//
// One byte per cycle unless stalled; a byte's verdict is registered after the input register.
// The per-byte compare and counter update sits between the input register and the
// result register. Reset clears the parse state to the method phase; no clearing pass.
// A stalled result holds the input register, and s_tready drops while both stages are
// full and m_tready is low.
`timescale 1ns / 1ps
`default_nettype none

module http_request_line_checker #(
    parameter int METHOD_LIMIT  = hrlc_pkg::METHOD_LIMIT_DEF,
    parameter int PATH_LIMIT    = hrlc_pkg::PATH_LIMIT_DEF,
    parameter int VERSION_LIMIT = hrlc_pkg::VERSION_LIMIT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,  // [7:0] data_byte
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [hrlc_pkg::OUT_TDATA_W-1:0]       m_tdata   // [2:0] verdict, [10:3] path_length
);

    logic                 in_valid_reg, in_valid_next;
    logic [7:0]           in_byte_reg;
    logic                 in_last_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [hrlc_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                 advance;
    hrlc_pkg::result_t    result;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? (in_valid_reg && result.valid) : out_valid_reg;

    hrlc_core #(
        .METHOD_LIMIT  (METHOD_LIMIT),
        .PATH_LIMIT    (PATH_LIMIT),
        .VERSION_LIMIT (VERSION_LIMIT)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (in_valid_reg && advance),
        .data_byte      (in_byte_reg),
        .end_of_request (in_last_reg),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_valid_reg && result.valid)
        begin
            out_data_reg <= hrlc_pkg::OUT_TDATA_W'({result.path_length, result.verdict});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== src/hrlc_checker.sv =====
// Port-level assertions for the HTTP request line checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "http_request_line_checker_assert.svh"

module hrlc_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [hrlc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    `HRLC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "request dropped under stall")
    `HRLC_ASSERT_NOW(a_out_cause, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "verdict without a byte")
    `HRLC_ASSERT_NOW(a_method_len, m_tvalid && (m_tdata[2:0] == hrlc_pkg::V_UNTERM || m_tdata[2:0] == hrlc_pkg::V_MLONG || m_tdata[2:0] == hrlc_pkg::V_NOTGET), m_tdata[10:3] == 8'd0, "method verdict with path bytes")
    `HRLC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[hrlc_pkg::OUT_TDATA_W-1:11] == '0, "nonzero padding")

endmodule

bind http_request_line_checker hrlc_checker u_hrlc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the HTTP request line checker stream block.
`timescale 1ns / 1ps

module tb;
    import hrlc_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_request;
        logic       typed;
        logic       has_result;
        verdict_t   verdict;
        logic [7:0] path_length;
    } intro_row_t;

    localparam int INTRO_ROWS = 24;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // predicted parse state
    phase_t parse_phase;
    int     field_len;
    int     path_len_cnt;
    logic   get_ok;
    logic   ten_ok;
    logic   eleven_ok;

    result_t verdict_q[$];
    int      errors = 0;
    int      requests_sent = 0;
    logic    src_steady = 1'b0;
    logic    sink_steady = 1'b0;

    intro_row_t intro_rows [INTRO_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 1'b1, V_UNTERM, 8'd0},
        '{8'h20, 1'b1, 1'b1, 1'b1, V_NOTGET, 8'd0},
        '{8'h47, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'h45, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'h54, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'h20, 1'b1, 1'b1, 1'b1, V_SIMPLE, 8'd0},
        '{8'h47, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'h45, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'h54, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'h20, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'h61, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'h00, 1'b1, 1'b1, 1'b1, V_BADVER, 8'd1},
        '{8'hFF, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'hFF, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'hFF, 1'b0, 1'b1, 1'b1, V_MLONG,  8'd0},
        '{8'h20, 1'b1, 1'b1, 1'b0, V_SIMPLE, 8'd0},
        '{8'h47, 1'b0, 1'b0, 1'b0, V_SIMPLE, 8'd0},
        '{8'h00, 1'b0, 1'b1, 1'b1, V_UNTERM, 8'd0},
        '{8'h78, 1'b1, 1'b1, 1'b0, V_SIMPLE, 8'd0}
    };

    http_request_line_checker DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [2:0] verdict, [10:3] path_length
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void clear_parse();
        parse_phase  = PH_METHOD;
        field_len    = 0;
        path_len_cnt = 0;
        get_ok       = 1'b1;
        ten_ok       = 1'b1;
        eleven_ok    = 1'b1;
    endfunction

    function automatic result_t conclude(input verdict_t v, input logic last);
        result_t r;
        r.valid       = 1'b1;
        r.verdict     = v;
        r.path_length = (path_len_cnt > 255) ? 8'd255 : 8'(path_len_cnt);
        if (last)
            clear_parse();
        else
            parse_phase = PH_DRAIN;
        return r;
    endfunction

    function automatic verdict_t version_verdict();
        return (field_len == 8 && (ten_ok || eleven_ok)) ? V_FULL : V_BADVER;
    endfunction

    function automatic result_t predict_verdict(input logic [7:0] b, input logic last);
        result_t none;
        none = '0;
        case (parse_phase)
            PH_METHOD:
            begin
                if (b == CHAR_SP)
                begin
                    if (!(get_ok && field_len == 3))
                        return conclude(V_NOTGET, last);
                    parse_phase  = PH_PATH;
                    field_len    = 0;
                    path_len_cnt = 0;
                    if (last)
                        return conclude(V_SIMPLE, 1'b1);
                    return none;
                end
                if (b == CHAR_NUL)
                    return conclude(V_UNTERM, last);
                if (field_len >= METHOD_LIMIT_DEF - 1)
                    return conclude(V_MLONG, last);
                if (field_len >= 3 || GET_TEXT[field_len] != b)
                    get_ok = 1'b0;
                field_len++;
                if (last)
                    return conclude(V_UNTERM, 1'b1);
                return none;
            end
            PH_PATH:
            begin
                if (b == CHAR_SP || b == CHAR_NUL)
                begin
                    parse_phase = PH_VERSION;
                    field_len   = 0;
                    ten_ok      = 1'b1;
                    eleven_ok   = 1'b1;
                    if (last)
                        return conclude(version_verdict(), 1'b1);
                    return none;
                end
                if (path_len_cnt >= PATH_LIMIT_DEF - 1)
                    return conclude(V_PLONG, last);
                path_len_cnt++;
                if (last)
                    return conclude(V_SIMPLE, 1'b1);
                return none;
            end
            PH_VERSION:
            begin
                if (b == CHAR_SP || b == CHAR_CR || b == CHAR_NUL)
                    return conclude(version_verdict(), last);
                if (field_len >= VERSION_LIMIT_DEF - 1)
                    return conclude(V_VLONG, last);
                if (field_len >= 8)
                begin
                    ten_ok    = 1'b0;
                    eleven_ok = 1'b0;
                end
                else
                begin
                    if (VER_TEN[field_len] != b)
                        ten_ok = 1'b0;
                    if (VER_ELEVEN[field_len] != b)
                        eleven_ok = 1'b0;
                end
                field_len++;
                if (last)
                    return conclude(version_verdict(), 1'b1);
                return none;
            end
            default:
            begin
                if (last)
                    clear_parse();
                return none;
            end
        endcase
    endfunction

    task automatic send_request_byte(input logic [7:0] b, input logic last, input logic typed,
                                     input result_t typed_res);
        int      gap;
        result_t res;
        gap = src_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        requests_sent++;
        res = predict_verdict(b, last);
        if (typed)
            res = typed_res;
        if (res.valid)
            verdict_q.push_back(res);
    endtask

    // any byte except NUL, space and CR
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == CHAR_NUL || b == CHAR_SP || b == CHAR_CR);
        return b;
    endfunction

    task automatic send_random_request();
        logic [7:0] line[$];
        int         pick;
        int         n;
        int         cut;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            // noise
            n = $urandom_range(1, 12);
            repeat (n) line.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if (pick < 88)
            begin
                line.push_back(GET_TEXT[0]);
                line.push_back(GET_TEXT[1]);
                line.push_back(GET_TEXT[2]);
            end
            else
            begin
                n = $urandom_range(0, 9);
                repeat (n)
                begin
                    if ($urandom_range(0, 3) == 0)
                        line.push_back(8'($urandom_range(0, 255)));
                    else
                        line.push_back(GET_TEXT[$urandom_range(0, 2)]);
                end
            end
            line.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : CHAR_SP);

            n = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 262) : $urandom_range(0, 24);
            repeat (n) line.push_back(plain_byte());
            line.push_back(($urandom_range(0, 9) == 0) ? CHAR_NUL : CHAR_SP);

            pick = $urandom_range(0, 9);
            for (int i = 0; i < 8; i++)
                line.push_back((pick >= 4) ? VER_ELEVEN[i] : VER_TEN[i]);
            if (pick == 7)
                line[line.size() - 1 - $urandom_range(0, 7)] = 8'($urandom_range(0, 255));
            else if (pick == 8)
                repeat ($urandom_range(1, 8)) void'(line.pop_back());
            else if (pick == 9)
                repeat ($urandom_range(1, 10)) line.push_back(plain_byte());

            case ($urandom_range(0, 3))
                0: line.push_back(CHAR_SP);
                1: line.push_back(CHAR_CR);
                2: line.push_back(CHAR_NUL);
                default: ;
            endcase
            repeat ($urandom_range(0, 4)) line.push_back(8'($urandom_range(0, 255)));
        end

        if ($urandom_range(0, 3) == 0)
        begin
            cut = $urandom_range(1, line.size());
            while (line.size() > cut) void'(line.pop_back());
        end
        for (int i = 0; i < line.size(); i++)
            send_request_byte(line[i], i == line.size() - 1, 1'b0, '0);
    endtask

    // result side: random stalls, check against oldest expectation
    initial begin
        int      gap;
        result_t exp_res;
        logic [2:0] got_verdict;
        logic [7:0] got_len;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                sink_steady = ~sink_steady;
            gap = sink_steady ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got_verdict = m_tdata[2:0];
            got_len     = m_tdata[10:3];
            if (verdict_q.size() == 0)
            begin
                $error("unexpected result: verdict %0d path_length %0d", got_verdict, got_len);
                errors++;
            end
            else
            begin
                exp_res = verdict_q.pop_front();
                if (got_verdict != exp_res.verdict)
                begin
                    $error("verdict: expected %0d, got %0d", exp_res.verdict, got_verdict);
                    errors++;
                end
                if (got_len != exp_res.path_length)
                begin
                    $error("path_length: expected %0d, got %0d", exp_res.path_length, got_len);
                    errors++;
                end
            end
        end
    end

    initial begin
        clear_parse();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (intro_rows[i])
            send_request_byte(intro_rows[i].data_byte, intro_rows[i].end_of_request,
                              intro_rows[i].typed,
                              '{intro_rows[i].has_result, intro_rows[i].verdict,
                                intro_rows[i].path_length});

        while (requests_sent < 1450 + INTRO_ROWS)
        begin
            if ($urandom_range(0, 7) == 0)
                src_steady = ~src_steady;
            send_random_request();
        end
        s_tvalid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("http_request_line_checker test passed");
        else
            $display("http_request_line_checker test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("http_request_line_checker test failed");
        $finish;
    end

endmodule
